>>> src/homography_footprint_overlap_macros.svh
// ----------------------------------------------------------------------------
// homography footprint overlap assertion macros
// shared assertion shorthands, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef HOMOGRAPHY_FOOTPRINT_OVERLAP_MACROS_SVH
`define HOMOGRAPHY_FOOTPRINT_OVERLAP_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define HFO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hfo assertion failed");

// condition must never be seen out of reset
`define HFO_ASSERT_NEVER(lbl, cond) \
  `HFO_ASSERT(lbl, !(cond))

`endif

>>> src/hfo_pkg.sv
// ----------------------------------------------------------------------------
// hfo_pkg
// widths, codes and shared types of the homography footprint overlap block
// ----------------------------------------------------------------------------
package hfo_pkg;

  // field widths
  localparam int COEF_W   = 48;
  localparam int XY_W     = 16;
  localparam int ID_W     = 16;
  localparam int CHUNK_PW = 24;
  localparam int CHUNK_SW = 16;

  // projection arithmetic
  localparam int PROD_W  = COEF_W + XY_W + 1;
  localparam int NUM_W   = COEF_W + XY_W + 2;
  localparam int Q_W     = 48;
  localparam int Q_FRAC  = 16;
  localparam int HI_SH   = Q_W - Q_FRAC;
  localparam int DIV_CYC = Q_W / 2;
  localparam int CNT_W   = $clog2(DIV_CYC + 1);
  localparam logic [Q_W-1:0] Q_MAX     = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN_MAG = {1'b1, {(Q_W-1){1'b0}}};

  // corners and queue
  localparam int NCORNER  = 4;
  localparam int CORNER_W = $clog2(NCORNER);
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // register port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_CHUNK_X      = 2'd0,
    REG_CHUNK_Y      = 2'd1,
    REG_CHUNK_WIDTH  = 2'd2,
    REG_CHUNK_HEIGHT = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_ABS,
    ST_LOAD,
    ST_DIV,
    ST_ACC,
    ST_DONE
  } back_state_e;

  // classified request as it sits in the queue
  typedef struct packed {
    logic [ID_W-1:0]              id;
    logic [XY_W-1:0]              w;
    logic [XY_W-1:0]              h;
    logic                         unknown;
    logic [8:0][COEF_W-1:0]       coef;
  } item_t;

  typedef struct packed {
    logic [CHUNK_PW-1:0] x;
    logic [CHUNK_PW-1:0] y;
    logic [CHUNK_SW-1:0] cw;
    logic [CHUNK_SW-1:0] ch;
  } cfg_t;

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } qstat_t;

endpackage

>>> src/hfo_if.sv
// ----------------------------------------------------------------------------
// hfo channel interfaces
// valid/ready channels for image requests and overlap results
// ----------------------------------------------------------------------------
interface hfo_item_if;
  logic                                 valid;
  logic                                 ready;
  logic        [hfo_pkg::ID_W-1:0]      image_id;
  logic        [hfo_pkg::XY_W-1:0]      image_width;
  logic        [hfo_pkg::XY_W-1:0]      image_height;
  logic signed [hfo_pkg::COEF_W-1:0]    coef_m0;
  logic signed [hfo_pkg::COEF_W-1:0]    coef_m1;
  logic signed [hfo_pkg::COEF_W-1:0]    coef_m2;
  logic signed [hfo_pkg::COEF_W-1:0]    coef_m3;
  logic signed [hfo_pkg::COEF_W-1:0]    coef_m4;
  logic signed [hfo_pkg::COEF_W-1:0]    coef_m5;
  logic signed [hfo_pkg::COEF_W-1:0]    coef_m6;
  logic signed [hfo_pkg::COEF_W-1:0]    coef_m7;
  logic signed [hfo_pkg::COEF_W-1:0]    coef_m8;

  modport source (output valid, image_id, image_width, image_height, coef_m0, coef_m1,
                  coef_m2, coef_m3, coef_m4, coef_m5, coef_m6, coef_m7, coef_m8,
                  input ready);
  modport sink   (input valid, image_id, image_width, image_height, coef_m0, coef_m1,
                  coef_m2, coef_m3, coef_m4, coef_m5, coef_m6, coef_m7, coef_m8,
                  output ready);
endinterface

interface hfo_res_if;
  logic                       valid;
  logic                       ready;
  logic [hfo_pkg::ID_W-1:0]   result_id;
  logic                       overlaps;

  modport source (output valid, result_id, overlaps, input ready);
  modport sink   (input valid, result_id, overlaps, output ready);
endinterface

>>> src/hfo_front.sv
// ----------------------------------------------------------------------------
// hfo_front
// takes image requests, flags unknown sizes and hands them to the queue
// ----------------------------------------------------------------------------
module hfo_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hfo_item_if.sink             item_i,
  input  hfo_pkg::qstat_t      qstat_i,
  output logic                 push_o,
  output hfo_pkg::item_t       entry_o
);

  logic           valid_q;
  hfo_pkg::item_t entry_q;
  logic           take;

  // slot is free or drains into the queue this cycle
  assign push_o       = valid_q && qstat_i.not_full;
  assign item_i.ready = !valid_q || qstat_i.not_full;
  assign take         = item_i.valid && item_i.ready;
  assign entry_o      = entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  // classify and capture the request
  always_ff @(posedge clk_i) begin
    if (take) begin
      entry_q.id      <= item_i.image_id;
      entry_q.w       <= item_i.image_width;
      entry_q.h       <= item_i.image_height;
      entry_q.unknown <= (item_i.image_width == '0) || (item_i.image_height == '0);
      entry_q.coef[0] <= item_i.coef_m0;
      entry_q.coef[1] <= item_i.coef_m1;
      entry_q.coef[2] <= item_i.coef_m2;
      entry_q.coef[3] <= item_i.coef_m3;
      entry_q.coef[4] <= item_i.coef_m4;
      entry_q.coef[5] <= item_i.coef_m5;
      entry_q.coef[6] <= item_i.coef_m6;
      entry_q.coef[7] <= item_i.coef_m7;
      entry_q.coef[8] <= item_i.coef_m8;
    end
  end

endmodule

>>> src/hfo_queue.sv
// ----------------------------------------------------------------------------
// hfo_queue
// short fifo between the front and the projection engine
// ----------------------------------------------------------------------------
module hfo_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  hfo_pkg::item_t       entry_i,
  input  logic                 pop_i,
  output hfo_pkg::item_t       head_o,
  output hfo_pkg::qstat_t      qstat_o
);

  hfo_pkg::item_t                  mem_q [hfo_pkg::QDEPTH];
  logic [hfo_pkg::QPTR_W-1:0]      wr_q;
  logic [hfo_pkg::QPTR_W-1:0]      rd_q;
  logic [hfo_pkg::QCNT_W-1:0]      cnt_q;

  assign qstat_o.not_empty = (cnt_q != '0);
  assign qstat_o.not_full  = (cnt_q != hfo_pkg::QCNT_W'(hfo_pkg::QDEPTH));
  assign head_o            = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

>>> src/hfo_div.sv
// ----------------------------------------------------------------------------
// hfo_div
// restoring divider, two quotient bits a cycle, saturated q32.16 result
// ----------------------------------------------------------------------------
module hfo_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [hfo_pkg::NUM_W-1:0]         n_mag_i,
  input  logic [hfo_pkg::NUM_W-1:0]         d_mag_i,
  input  logic                              neg_i,
  output logic                              done_o,
  output logic [hfo_pkg::Q_W-1:0]           q_o
);

  logic                          busy_q, fin_q, done_q;
  logic [hfo_pkg::CNT_W-1:0]     cnt_q;
  logic [hfo_pkg::NUM_W-1:0]     r_q, d_q;
  logic [hfo_pkg::Q_W-1:0]       lo_q, qb_q, q_q;
  logic                          ovf_q, neg_q;
  logic [hfo_pkg::NUM_W:0]       s1, s2;
  logic [hfo_pkg::Q_W-1:0]       sat;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [hfo_pkg::NUM_W:0] step(input logic [hfo_pkg::NUM_W-1:0] r,
                                                   input logic b,
                                                   input logic [hfo_pkg::NUM_W-1:0] d);
    logic [hfo_pkg::NUM_W:0] t;
    logic [hfo_pkg::NUM_W:0] dx;
    t  = {r, b};
    dx = {1'b0, d};
    if (t >= dx) begin
      t = t - dx;
      return {1'b1, t[hfo_pkg::NUM_W-1:0]};
    end
    return {1'b0, t[hfo_pkg::NUM_W-1:0]};
  endfunction

  assign s1 = step(r_q, lo_q[hfo_pkg::Q_W-1], d_q);
  assign s2 = step(s1[hfo_pkg::NUM_W-1:0], lo_q[hfo_pkg::Q_W-2], d_q);

  // sign and saturation of the finished quotient
  always_comb begin
    if (neg_q) begin
      if (ovf_q || (qb_q > hfo_pkg::Q_MIN_MAG)) begin
        sat = hfo_pkg::Q_MIN_MAG;
      end else begin
        sat = '0 - qb_q;
      end
    end else begin
      if (ovf_q || (qb_q > hfo_pkg::Q_MAX)) begin
        sat = hfo_pkg::Q_MAX;
      end else begin
        sat = qb_q;
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= hfo_pkg::CNT_W'(hfo_pkg::DIV_CYC);
    end else begin
      fin_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == hfo_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  // datapath; quotient overflows when n / 2^32 >= d
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q   <= d_mag_i;
      neg_q <= neg_i;
      ovf_q <= (n_mag_i >> hfo_pkg::HI_SH) >= d_mag_i;
      r_q   <= n_mag_i >> hfo_pkg::HI_SH;
      lo_q  <= {n_mag_i[hfo_pkg::HI_SH-1:0], {hfo_pkg::Q_FRAC{1'b0}}};
      qb_q  <= '0;
    end else if (busy_q) begin
      r_q  <= s2[hfo_pkg::NUM_W-1:0];
      lo_q <= lo_q << 2;
      qb_q <= {qb_q[hfo_pkg::Q_W-3:0], s1[hfo_pkg::NUM_W], s2[hfo_pkg::NUM_W]};
    end
    if (fin_q) begin
      q_q <= sat;
    end
  end

endmodule

>>> src/hfo_back.sv
// ----------------------------------------------------------------------------
// hfo_back
// projects the four corners, builds the bounding box and tests the chunk; unknown sizes report an overlap
// ----------------------------------------------------------------------------
module hfo_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hfo_pkg::item_t       head_i,
  input  hfo_pkg::qstat_t      qstat_i,
  output logic                 pop_o,
  input  hfo_pkg::cfg_t        cfg_i,
  hfo_res_if.source            result_o
);

  hfo_pkg::back_state_e                    state_q, state_d;
  logic [hfo_pkg::CORNER_W-1:0]            corner_q;
  hfo_pkg::item_t                          it_q;
  logic [5:0][hfo_pkg::PROD_W-1:0]         prod_q;
  logic [2:0][hfo_pkg::NUM_W-1:0]          sum_q;
  logic [hfo_pkg::NUM_W-1:0]               nx_q, ny_q, dm_q;
  logic                                    negx_q, negy_q;
  logic signed [hfo_pkg::Q_W-1:0]          minx_q, maxx_q, miny_q, maxy_q;
  logic                                    out_valid_q, out_ov_q;
  logic [hfo_pkg::ID_W-1:0]                out_id_q;
  logic                                    div_start, out_load, hit;
  logic                                    donex, doney;
  logic [hfo_pkg::Q_W-1:0]                 qx, qy;
  logic signed [hfo_pkg::Q_W-1:0]          px, py;
  logic [hfo_pkg::XY_W-1:0]                cx, cy;
  logic [hfo_pkg::NUM_W-1:0]               s0, s1, s2, dabs;
  logic signed [hfo_pkg::Q_W-1:0]          ex, ey, cx0, cx1, cy0, cy1;

  // signed coefficient times unsigned coordinate
  function automatic logic [hfo_pkg::PROD_W-1:0] mul(input logic [hfo_pkg::COEF_W-1:0] c,
                                                     input logic [hfo_pkg::XY_W-1:0] v);
    logic signed [hfo_pkg::PROD_W-1:0] a;
    logic signed [hfo_pkg::PROD_W-1:0] b;
    a = hfo_pkg::PROD_W'($signed(c));
    b = hfo_pkg::PROD_W'($signed({1'b0, v}));
    return a * b;
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hfo_pkg::ST_IDLE: begin
        if (qstat_i.not_empty) begin
          state_d = head_i.unknown ? hfo_pkg::ST_DONE : hfo_pkg::ST_MUL;
        end
      end
      hfo_pkg::ST_MUL:  state_d = hfo_pkg::ST_SUM;
      hfo_pkg::ST_SUM:  state_d = hfo_pkg::ST_ABS;
      hfo_pkg::ST_ABS:  state_d = hfo_pkg::ST_LOAD;
      hfo_pkg::ST_LOAD: state_d = hfo_pkg::ST_DIV;
      hfo_pkg::ST_DIV: begin
        if (donex && doney) begin
          state_d = hfo_pkg::ST_ACC;
        end
      end
      hfo_pkg::ST_ACC: begin
        state_d = (corner_q == hfo_pkg::CORNER_W'(hfo_pkg::NCORNER - 1)) ?
                  hfo_pkg::ST_DONE : hfo_pkg::ST_MUL;
      end
      hfo_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = hfo_pkg::ST_IDLE;
        end
      end
      default: state_d = hfo_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop_o     = (state_q == hfo_pkg::ST_IDLE) && qstat_i.not_empty;
    div_start = (state_q == hfo_pkg::ST_LOAD);
    out_load  = (state_q == hfo_pkg::ST_DONE) && (!out_valid_q || result_o.ready);
  end

  // corner operands and row sums
  assign cx   = corner_q[0] ? it_q.w : '0;
  assign cy   = corner_q[1] ? it_q.h : '0;
  assign s0   = hfo_pkg::NUM_W'($signed(prod_q[0])) + hfo_pkg::NUM_W'($signed(prod_q[1]))
              + hfo_pkg::NUM_W'($signed(it_q.coef[2]));
  assign s1   = hfo_pkg::NUM_W'($signed(prod_q[2])) + hfo_pkg::NUM_W'($signed(prod_q[3]))
              + hfo_pkg::NUM_W'($signed(it_q.coef[5]));
  assign s2   = hfo_pkg::NUM_W'($signed(prod_q[4])) + hfo_pkg::NUM_W'($signed(prod_q[5]))
              + hfo_pkg::NUM_W'($signed(it_q.coef[8]));
  assign dabs = sum_q[2][hfo_pkg::NUM_W-1] ? ('0 - sum_q[2]) : sum_q[2];

  hfo_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_mag_i (nx_q),
    .d_mag_i (dm_q),
    .neg_i   (negx_q),
    .done_o  (donex),
    .q_o     (qx)
  );

  hfo_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_mag_i (ny_q),
    .d_mag_i (dm_q),
    .neg_i   (negy_q),
    .done_o  (doney),
    .q_o     (qy)
  );

  assign px = $signed(qx);
  assign py = $signed(qy);

  // chunk edges in q32.16 and strict overlap
  assign ex  = hfo_pkg::Q_W'($signed(cfg_i.x));
  assign ey  = hfo_pkg::Q_W'($signed(cfg_i.y));
  assign cx0 = ex <<< hfo_pkg::Q_FRAC;
  assign cy0 = ey <<< hfo_pkg::Q_FRAC;
  assign cx1 = $signed(ex + hfo_pkg::Q_W'({1'b0, cfg_i.cw})) <<< hfo_pkg::Q_FRAC;
  assign cy1 = $signed(ey + hfo_pkg::Q_W'({1'b0, cfg_i.ch})) <<< hfo_pkg::Q_FRAC;
  assign hit = (minx_q < cx1) && (maxx_q > cx0) && (miny_q < cy1) && (maxy_q > cy0);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hfo_pkg::ST_IDLE;
      corner_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        corner_q <= '0;
      end else if (state_q == hfo_pkg::ST_ACC) begin
        corner_q <= corner_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      it_q <= head_i;
    end
    if (state_q == hfo_pkg::ST_MUL) begin
      prod_q[0] <= mul(it_q.coef[0], cx);
      prod_q[1] <= mul(it_q.coef[1], cy);
      prod_q[2] <= mul(it_q.coef[3], cx);
      prod_q[3] <= mul(it_q.coef[4], cy);
      prod_q[4] <= mul(it_q.coef[6], cx);
      prod_q[5] <= mul(it_q.coef[7], cy);
    end
    if (state_q == hfo_pkg::ST_SUM) begin
      sum_q[0] <= s0;
      sum_q[1] <= s1;
      sum_q[2] <= s2;
    end
    // magnitudes, a zero denominator becomes plus one lsb
    if (state_q == hfo_pkg::ST_ABS) begin
      nx_q   <= sum_q[0][hfo_pkg::NUM_W-1] ? ('0 - sum_q[0]) : sum_q[0];
      ny_q   <= sum_q[1][hfo_pkg::NUM_W-1] ? ('0 - sum_q[1]) : sum_q[1];
      dm_q   <= (dabs == '0) ? hfo_pkg::NUM_W'(1) : dabs;
      negx_q <= sum_q[0][hfo_pkg::NUM_W-1] ^ sum_q[2][hfo_pkg::NUM_W-1];
      negy_q <= sum_q[1][hfo_pkg::NUM_W-1] ^ sum_q[2][hfo_pkg::NUM_W-1];
    end
    // bounding box
    if (state_q == hfo_pkg::ST_ACC) begin
      if (corner_q == '0 || px < minx_q) begin
        minx_q <= px;
      end
      if (corner_q == '0 || px > maxx_q) begin
        maxx_q <= px;
      end
      if (corner_q == '0 || py < miny_q) begin
        miny_q <= py;
      end
      if (corner_q == '0 || py > maxy_q) begin
        maxy_q <= py;
      end
    end
    if (out_load) begin
      out_id_q <= it_q.id;
      out_ov_q <= it_q.unknown || hit;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.result_id = out_id_q;
  assign result_o.overlaps  = out_ov_q;

endmodule

>>> src/homography_footprint_overlap.sv
// an image of unknown size skips the projection and goes straight to its overlap result;
//   for other images the engine projects the four corners one after another, one image at a time
// each corner goes through two restoring dividers, one per coordinate, that produce
//   two quotient bits a cycle
// new requests are taken into a front slot and a two-entry queue while the engine works
// reset: asynchronous, active low; chunk registers clear to zero, all channels empty
// ----------------------------------------------------------------------------
// homography_footprint_overlap
// projects an image footprint through a homography and tests chunk overlap
// ----------------------------------------------------------------------------
module homography_footprint_overlap (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hfo_item_if.sink                      item_i,
  hfo_res_if.source                     result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hfo_pkg::APB_AW-1:0]    paddr,
  input  logic [hfo_pkg::APB_DW-1:0]    pwdata,
  output logic [hfo_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  hfo_pkg::cfg_t   cfg_q;
  hfo_pkg::item_t  entry, head;
  hfo_pkg::qstat_t qstat;
  logic            push, pop;
  hfo_pkg::reg_e   idx;

  assign pready = 1'b1;
  assign idx    = hfo_pkg::reg_e'(paddr[hfo_pkg::APB_AW-1:2]);

  // chunk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        hfo_pkg::REG_CHUNK_X:      cfg_q.x  <= pwdata[hfo_pkg::CHUNK_PW-1:0];
        hfo_pkg::REG_CHUNK_Y:      cfg_q.y  <= pwdata[hfo_pkg::CHUNK_PW-1:0];
        hfo_pkg::REG_CHUNK_WIDTH:  cfg_q.cw <= pwdata[hfo_pkg::CHUNK_SW-1:0];
        hfo_pkg::REG_CHUNK_HEIGHT: cfg_q.ch <= pwdata[hfo_pkg::CHUNK_SW-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (idx)
      hfo_pkg::REG_CHUNK_X:      prdata = hfo_pkg::APB_DW'(cfg_q.x);
      hfo_pkg::REG_CHUNK_Y:      prdata = hfo_pkg::APB_DW'(cfg_q.y);
      hfo_pkg::REG_CHUNK_WIDTH:  prdata = hfo_pkg::APB_DW'(cfg_q.cw);
      hfo_pkg::REG_CHUNK_HEIGHT: prdata = hfo_pkg::APB_DW'(cfg_q.ch);
      default:                   prdata = '0;
    endcase
  end

  hfo_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .qstat_i (qstat),
    .push_o  (push),
    .entry_o (entry)
  );

  hfo_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  hfo_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .qstat_i  (qstat),
    .pop_o    (pop),
    .cfg_i    (cfg_q),
    .result_o (result_o)
  );

endmodule

>>> src/hfo_checker.sv
// ----------------------------------------------------------------------------
// hfo_checker
// port-level checks of the overlap block, bound to the top level
// ----------------------------------------------------------------------------
`include "homography_footprint_overlap_macros.svh"

module hfo_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [hfo_pkg::ID_W-1:0]    out_id_i,
  input  logic                        out_ovl_i,
  input  logic                        pready_i
);

  localparam int PEND_MAX = hfo_pkg::QDEPTH + 3;
  localparam int PEND_W   = $clog2(PEND_MAX + 2);

  logic [PEND_W-1:0] pend_q;
  logic              in_acc, out_acc, out_wait;

  assign in_acc   = in_valid_i && in_ready_i;
  assign out_acc  = out_valid_i && out_ready_i;
  assign out_wait = out_valid_i && !out_ready_i;

  // requests in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  `HFO_ASSERT(a_pready_high, pready_i)
  `HFO_ASSERT(a_out_hold, out_wait |=> out_valid_i && $stable(out_id_i) && $stable(out_ovl_i))
  `HFO_ASSERT_NEVER(a_no_spurious, out_acc && (pend_q == '0))
  `HFO_ASSERT_NEVER(a_bounded, pend_q > PEND_W'(PEND_MAX))

endmodule

bind homography_footprint_overlap hfo_checker u_hfo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_id_i    (result_o.result_id),
  .out_ovl_i   (result_o.overlaps),
  .pready_i    (pready)
);

>>> tb/sv/tb_homography_footprint_overlap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homography footprint overlap testbench
// drives image requests through the valid/ready channel, projects the corners
// with an exact wide-integer model of the block and checks every overlap result
// ----------------------------------------------------------------------------
module tb_homography_footprint_overlap;

  localparam int STALL_LIMIT = 4000;
  localparam int RAND_PER_PHASE = 125;
  localparam int N_DIR = 12;
  localparam logic [hfo_pkg::COEF_W-1:0] ONE_Q = 48'h0000_0100_0000;
  localparam logic [hfo_pkg::COEF_W-1:0] MAX_C = 48'h7FFF_FFFF_FFFF;
  localparam logic [hfo_pkg::COEF_W-1:0] MIN_C = 48'h8000_0000_0000;
  localparam logic [hfo_pkg::COEF_W-1:0] LSB_C = 48'h0000_0000_0001;

  typedef struct packed {
    logic [hfo_pkg::ID_W-1:0]        id;
    logic [hfo_pkg::XY_W-1:0]        w;
    logic [hfo_pkg::XY_W-1:0]        h;
    logic [8:0][hfo_pkg::COEF_W-1:0] m;
  } img_req_t;

  typedef struct packed {
    logic [hfo_pkg::ID_W-1:0] id;
    logic                     ovl;
  } ovl_res_t;

  typedef struct {
    img_req_t req;
    bit       known;
    bit       ovl;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [hfo_pkg::APB_AW-1:0] paddr = '0;
  logic [hfo_pkg::APB_DW-1:0] pwdata = '0;
  logic [hfo_pkg::APB_DW-1:0] prdata;
  logic pready;

  hfo_item_if item_if ();
  hfo_res_if  res_if ();

  homography_footprint_overlap dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if.sink),
    .result_o (res_if.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // chunk rectangle as the model sees it
  logic signed [hfo_pkg::CHUNK_PW-1:0] chunk_x_q = '0, chunk_y_q = '0;
  logic [hfo_pkg::CHUNK_SW-1:0] chunk_w_q = '0, chunk_h_q = '0;

  ovl_res_t overlap_q[$];
  dir_row_t dir_rows[N_DIR];
  int mismatches = 0;
  int checked = 0;
  int idle_cycles = 0;
  int sent = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // projected Q32.16 quotient, truncated and saturated
  function automatic logic signed [127:0] q_quot(logic signed [127:0] num,
                                                 logic signed [127:0] den);
    logic signed [127:0] q;
    if (den == 0) den = 1;
    q = (num <<< hfo_pkg::Q_FRAC) / den;
    if (q > 128'sh7FFF_FFFF_FFFF) q = 128'sh7FFF_FFFF_FFFF;
    if (q < -128'sh8000_0000_0000) q = -128'sh8000_0000_0000;
    return q;
  endfunction

  // bounding box of the four projected corners against the chunk
  function automatic logic footprint_overlap(img_req_t r);
    logic signed [127:0] c[9];
    logic signed [127:0] cx, cy, den, px, py;
    logic signed [127:0] min_x, max_x, min_y, max_y, x0, x1, y0, y1;
    if (r.w == 0 || r.h == 0) return 1'b1;
    for (int i = 0; i < 9; i++) c[i] = $signed(r.m[8-i]);
    for (int k = 0; k < hfo_pkg::NCORNER; k++) begin
      cx = (k & 1) ? {112'b0, r.w} : 128'sd0;
      cy = (k & 2) ? {112'b0, r.h} : 128'sd0;
      den = c[6] * cx + c[7] * cy + c[8];
      px = q_quot(c[0] * cx + c[1] * cy + c[2], den);
      py = q_quot(c[3] * cx + c[4] * cy + c[5], den);
      if (k == 0 || px < min_x) min_x = px;
      if (k == 0 || px > max_x) max_x = px;
      if (k == 0 || py < min_y) min_y = py;
      if (k == 0 || py > max_y) max_y = py;
    end
    x0 = 128'(chunk_x_q) <<< hfo_pkg::Q_FRAC;
    y0 = 128'(chunk_y_q) <<< hfo_pkg::Q_FRAC;
    x1 = (128'(chunk_x_q) + $signed({112'b0, chunk_w_q})) <<< hfo_pkg::Q_FRAC;
    y1 = (128'(chunk_y_q) + $signed({112'b0, chunk_h_q})) <<< hfo_pkg::Q_FRAC;
    return (min_x < x1) && (max_x > x0) && (min_y < y1) && (max_y > y0);
  endfunction

  // coefficients are listed m0 first
  function automatic dir_row_t mk_row(logic [15:0] id, logic [15:0] w, logic [15:0] h,
      logic [hfo_pkg::COEF_W-1:0] a0, a1, a2, a3, a4, a5, a6, a7, a8, bit known, bit ovl);
    dir_row_t d;
    d.req.id = id;
    d.req.w = w;
    d.req.h = h;
    d.req.m = {a0, a1, a2, a3, a4, a5, a6, a7, a8};
    d.known = known;
    d.ovl = ovl;
    return d;
  endfunction

  function automatic logic [hfo_pkg::COEF_W-1:0] rand_coef();
    return hfo_pkg::COEF_W'({$urandom(), $urandom()});
  endfunction

  // small signed coefficient centered on zero
  function automatic logic [hfo_pkg::COEF_W-1:0] small_coef(int span);
    return hfo_pkg::COEF_W'(int'($urandom_range(0, span)) - span / 2);
  endfunction

  // plausible camera homography placed around the chunk, or a fully random matrix
  function automatic img_req_t gen_image(logic [15:0] id);
    img_req_t r;
    longint tx, ty;
    r.id = id;
    case ($urandom_range(0, 19))
      0:       r.w = '0;
      1:       r.w = 16'hFFFF;
      default: r.w = 16'($urandom_range(1, 4000));
    endcase
    case ($urandom_range(0, 19))
      0:       r.h = '0;
      1:       r.h = 16'hFFFF;
      default: r.h = 16'($urandom_range(1, 4000));
    endcase
    if ($urandom_range(0, 9) < 3) begin
      for (int i = 0; i < 9; i++) r.m[i] = rand_coef();
    end else begin
      tx = longint'(chunk_x_q) + longint'($urandom_range(0, 8000)) - 64'sd5000;
      ty = longint'(chunk_y_q) + longint'($urandom_range(0, 8000)) - 64'sd5000;
      r.m[8] = ONE_Q + small_coef(1 << 24);
      r.m[7] = small_coef(1 << 21);
      r.m[6] = hfo_pkg::COEF_W'(tx <<< 24) + hfo_pkg::COEF_W'($urandom_range(0, 1 << 24));
      r.m[5] = small_coef(1 << 21);
      r.m[4] = ONE_Q + small_coef(1 << 24);
      r.m[3] = hfo_pkg::COEF_W'(ty <<< 24) + hfo_pkg::COEF_W'($urandom_range(0, 1 << 24));
      r.m[2] = small_coef(1 << 10);
      r.m[1] = small_coef(1 << 10);
      r.m[0] = ($urandom_range(0, 7) == 0) ? rand_coef() : ONE_Q;
    end
    return r;
  endfunction

  // apb write: setup then access
  task automatic reg_write(hfo_pkg::reg_e idx, logic [hfo_pkg::APB_DW-1:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = hfo_pkg::APB_AW'(idx) << 2;
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_chunk(logic signed [23:0] x, logic signed [23:0] y,
                           logic [15:0] cw, logic [15:0] ch);
    while (overlap_q.size() != 0) @(posedge clk_i);
    reg_write(hfo_pkg::REG_CHUNK_X, 32'(x));
    reg_write(hfo_pkg::REG_CHUNK_Y, 32'(y));
    reg_write(hfo_pkg::REG_CHUNK_WIDTH, 32'(cw));
    reg_write(hfo_pkg::REG_CHUNK_HEIGHT, 32'(ch));
    chunk_x_q = x;
    chunk_y_q = y;
    chunk_w_q = cw;
    chunk_h_q = ch;
  endtask

  task automatic send_image(img_req_t r);
    repeat ($urandom_range(0, 10)) @(negedge clk_i);
    item_if.valid = 1'b1;
    item_if.image_id = r.id;
    item_if.image_width = r.w;
    item_if.image_height = r.h;
    {item_if.coef_m0, item_if.coef_m1, item_if.coef_m2, item_if.coef_m3, item_if.coef_m4,
     item_if.coef_m5, item_if.coef_m6, item_if.coef_m7, item_if.coef_m8} = r.m;
    do @(posedge clk_i); while (!item_if.ready);
    @(negedge clk_i);
    item_if.valid = 1'b0;
    sent++;
  endtask

  task automatic random_phase();
    for (int i = 0; i < RAND_PER_PHASE; i++)
      send_image(gen_image(16'($urandom_range(0, 16'hFFFF))));
  endtask

  // predict on every accepted request
  always @(posedge clk_i) begin
    ovl_res_t e;
    img_req_t r;
    if (rst_ni && item_if.valid && item_if.ready) begin
      r.id = item_if.image_id;
      r.w = item_if.image_width;
      r.h = item_if.image_height;
      r.m = {item_if.coef_m0, item_if.coef_m1, item_if.coef_m2, item_if.coef_m3,
             item_if.coef_m4, item_if.coef_m5, item_if.coef_m6, item_if.coef_m7,
             item_if.coef_m8};
      e.id = r.id;
      e.ovl = footprint_overlap(r);
      overlap_q.insert(overlap_q.size(), e);
    end
  end

  // check each result against the oldest prediction
  always @(posedge clk_i) begin
    ovl_res_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      checked++;
      if (overlap_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result id %h", res_if.result_id);
      end else begin
        e = overlap_q.pop_front();
        if (e.id !== res_if.result_id || e.ovl !== res_if.overlaps) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected id %h ovl %b, got id %h ovl %b",
                     e.id, e.ovl, res_if.result_id, res_if.overlaps);
        end
      end
    end
  end

  // result side stalls a random number of cycles per result
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready = 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk_i);
      res_if.ready = 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && rst_ni));
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    item_if.valid = 1'b0;
    item_if.image_id = '0;
    item_if.image_width = '0;
    item_if.image_height = '0;
    {item_if.coef_m0, item_if.coef_m1, item_if.coef_m2, item_if.coef_m3, item_if.coef_m4,
     item_if.coef_m5, item_if.coef_m6, item_if.coef_m7, item_if.coef_m8} = '0;

    // directed rows, run against the reset chunk (empty at the origin)
    dir_rows[0] = mk_row(16'h0000, 16'h0000, 16'h0005, ONE_Q, '0, '0, '0, ONE_Q, '0,
                         '0, '0, ONE_Q, 1'b1, 1'b1);
    dir_rows[1] = mk_row(16'hFFFF, 16'h0005, 16'h0000, MAX_C, MAX_C, MAX_C, MAX_C,
                         MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, 1'b1, 1'b1);
    dir_rows[2] = mk_row(16'h1234, 16'h0000, 16'h0000, MIN_C, MIN_C, MIN_C, MIN_C,
                         MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, 1'b1, 1'b1);
    // all-zero matrix: zero denominator, every corner lands on the origin
    dir_rows[3] = mk_row(16'h0001, 16'h000A, 16'h000A, '0, '0, '0, '0, '0, '0,
                         '0, '0, '0, 1'b1, 1'b0);
    dir_rows[4] = mk_row(16'h0002, 16'hFFFF, 16'hFFFF, ONE_Q, '0, '0, '0, ONE_Q, '0,
                         '0, '0, ONE_Q, 1'b0, 1'b0);
    dir_rows[5] = mk_row(16'h0003, 16'h0010, 16'h0010, '0, '0, ONE_Q, '0, '0, ONE_Q,
                         '0, '0, '0, 1'b0, 1'b0);
    dir_rows[6] = mk_row(16'h0004, 16'hFFFF, 16'hFFFF, MAX_C, MAX_C, MAX_C, MAX_C,
                         MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, 1'b0, 1'b0);
    dir_rows[7] = mk_row(16'h0005, 16'hFFFF, 16'hFFFF, MIN_C, MIN_C, MIN_C, MIN_C,
                         MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, 1'b0, 1'b0);
    dir_rows[8] = mk_row(16'h0006, 16'h0100, 16'h0080, ONE_Q, '0, '0, '0, ONE_Q, '0,
                         '0, '0, -ONE_Q, 1'b0, 1'b0);
    dir_rows[9] = mk_row(16'h0007, 16'h0001, 16'h0001, LSB_C, '0, MAX_C, '0, LSB_C, MIN_C,
                         '0, '0, LSB_C, 1'b0, 1'b0);
    dir_rows[10] = mk_row(16'h0008, 16'h0100, 16'h0100, ONE_Q, '0, -ONE_Q, '0, ONE_Q,
                          -ONE_Q, -48'sd65536, '0, ONE_Q, 1'b0, 1'b0);
    dir_rows[11] = mk_row(16'h0009, 16'hFFFF, 16'h0001, MIN_C, MAX_C, LSB_C, MAX_C, MIN_C,
                          '1, MAX_C, MIN_C, '0, 1'b0, 1'b0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].known && footprint_overlap(dir_rows[i].req) !== dir_rows[i].ovl) begin
        mismatches++;
        if (mismatches <= 10) $display("model disagrees with table on id %h",
                                       dir_rows[i].req.id);
      end
      send_image(dir_rows[i].req);
    end
    random_phase();

    set_chunk(-24'sd8388608, -24'sd8388608, 16'hFFFF, 16'hFFFF);
    random_phase();
    set_chunk(24'sd8388607, 24'sd8388607, 16'h0000, 16'h0000);
    random_phase();
    set_chunk(24'sd100, -24'sd50, 16'hFFFF, 16'h0000);
    random_phase();
    for (int p = 0; p < 2; p++) begin
      set_chunk(24'(int'($urandom_range(0, 6000)) - 3000),
                24'(int'($urandom_range(0, 6000)) - 3000),
                16'($urandom_range(0, 5000)), 16'($urandom_range(0, 5000)));
      random_phase();
    end

    while (overlap_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);

    $display("sent %0d images over six chunk settings, %0d results checked", sent, checked);
    if (mismatches == 0 && overlap_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
